>>> rtl/core/dsp_adpcm_decoder_assert.svh
// ----------------------------------------------------------------------------
// ADPCM decoder assertion macros
// Shorthands for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef DSP_ADPCM_DECODER_ASSERT_SVH
`define DSP_ADPCM_DECODER_ASSERT_SVH

// Same-cycle implication on clk, off while arst_n is low.
`define ADPCM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adpcm check failed");

// Next-cycle implication on clk, off while arst_n is low.
`define ADPCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adpcm check failed");

`endif

>>> rtl/core/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// ADPCM decoder package
// Shared constants, types and helper functions of the ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

	localparam int SAMPLE_COUNT_BITS_DEF = 32;
	localparam int CFG_DATA_W            = 64;
	localparam int CFG_INDEX_W           = 3;
	localparam int COEF_W                = 16;
	localparam int PCM_W                 = 16;
	localparam int NIB_W                 = 4;
	localparam int EXP_W                 = 4;
	localparam int PAIR_W                = 3;
	localparam int FPOS_W                = 3;
	localparam int FRAC_BITS             = 11;
	localparam int ACC_W                 = 34;
	localparam int Q_W                   = ACC_W - FRAC_BITS;
	localparam int ROUND_BIAS            = 1024;
	localparam int PCM_MAX               = 32767;
	localparam int PCM_MIN               = -32768;
	localparam int BANK_COUNT            = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_A       = 3'd0,
		REG_COEF_B       = 3'd1,
		REG_COEF_C       = 3'd2,
		REG_COEF_D       = 3'd3,
		REG_SAMPLE_COUNT = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		MAC_HOLD,
		MAC_LOAD,
		MAC_ACC
	} mac_op_t;

	typedef struct packed {
		mac_op_t                  op;
		logic signed [NIB_W-1:0]  nibble;
		logic        [EXP_W-1:0]  exponent;
	} mac_ctrl_t;

	// Floor-shift the accumulator by the fraction bits and clamp to 16 bits.
	function automatic logic signed [PCM_W-1:0] sat_pcm(input logic signed [ACC_W-1:0] acc);
		logic signed [Q_W-1:0] q;
		q = acc[ACC_W-1:FRAC_BITS];
		if (q > Q_W'(PCM_MAX))
			return PCM_W'(PCM_MAX);
		else if (q < Q_W'(PCM_MIN))
			return PCM_W'(PCM_MIN);
		else
			return q[PCM_W-1:0];
	endfunction

endpackage

>>> rtl/core/adpcm_if.sv
// ----------------------------------------------------------------------------
// ADPCM decoder channels
// Valid/ready channels for stream bytes in and PCM samples out.
// ----------------------------------------------------------------------------
interface adpcm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_start;

	modport source (output valid, output data_byte, output stream_start, input ready);
	modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface adpcm_pcm_if;
	logic                               valid;
	logic                               ready;
	logic signed [adpcm_pkg::PCM_W-1:0] pcm_sample;
	logic                               final_sample;

	modport source (output valid, output pcm_sample, output final_sample, input ready);
	modport sink   (input valid, input pcm_sample, input final_sample, output ready);
endinterface

>>> rtl/core/adpcm_mac.sv
// ----------------------------------------------------------------------------
// ADPCM multiply-accumulate unit
// Shared 16x16 signed multiplier with a wide accumulator; loads the scaled
// nibble term, then adds a coefficient-history product per cycle in MAC_ACC.
// ----------------------------------------------------------------------------
module adpcm_mac (
	input  logic                                  clk,
	input  adpcm_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [adpcm_pkg::COEF_W-1:0]   coef,
	input  logic signed [adpcm_pkg::PCM_W-1:0]    hist,
	output logic signed [adpcm_pkg::ACC_W-1:0]    acc
);

	logic signed [adpcm_pkg::ACC_W-1:0]                 acc_q;
	logic signed [adpcm_pkg::COEF_W+adpcm_pkg::PCM_W-1:0] prod;
	logic signed [adpcm_pkg::ACC_W-1:0]                 prod_ext;
	logic signed [adpcm_pkg::ACC_W-1:0]                 load_val;

	assign prod     = coef * hist;
	assign prod_ext = adpcm_pkg::ACC_W'(prod);
	// (nibble << exponent) << 11, plus the rounding bias
	assign load_val = ((adpcm_pkg::ACC_W'(ctrl.nibble) <<< ctrl.exponent)
		<<< adpcm_pkg::FRAC_BITS) + adpcm_pkg::ACC_W'(adpcm_pkg::ROUND_BIAS);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			adpcm_pkg::MAC_LOAD: acc_q <= load_val;
			adpcm_pkg::MAC_ACC:  acc_q <= acc_q + prod_ext;
			default:             acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/dsp_adpcm_decoder.sv
// ----------------------------------------------------------------------------
// DSP ADPCM decoder
// One-channel 4-bit DSP ADPCM decoder built around a shared multiplier.
// ----------------------------------------------------------------------------
// Takes one stream byte per item and gives 16-bit PCM samples. Frames are
// eight bytes: a header (low nibble = scale exponent, bits 6:4 = coefficient
// pair) and seven data bytes of two signed nibbles each, high nibble first.
// Each sample is sat16((((n << exp) << 11) + c1*h1 + c2*h2 + 1024) >>> 11),
// computed on one multiply-accumulate unit in four steps: load the scaled
// nibble, add c1*h1, add c2*h2, then clamp and write the output register.
// A header byte sets the exponent and pair; a data byte runs the four
// steps once per sample, for one sample only when the count runs out after
// its first; the last step waits while the output register is still full.
// stream_start clears history, the sample counter and the frame position
// before its byte is handled. Once sample_count samples have gone out,
// bytes are dropped until the next stream_start; the last sample carries
// final_sample. Write the coefficient banks and sample_count only while the
// block is idle.
// ----------------------------------------------------------------------------
`include "dsp_adpcm_decoder_assert.svh"

module dsp_adpcm_decoder #(
	parameter int SAMPLE_COUNT_BITS = adpcm_pkg::SAMPLE_COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [adpcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0]    cfg_data,
	adpcm_byte_if.sink                          stream,
	adpcm_pcm_if.source                         pcm
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC1,
		ST_MAC2,
		ST_DONE
	} state_t;

	state_t                                    state_q;

	// configuration
	logic [adpcm_pkg::CFG_DATA_W-1:0]          coef_q [adpcm_pkg::BANK_COUNT];
	logic [SAMPLE_COUNT_BITS-1:0]              count_q;

	// decoder state
	logic signed [adpcm_pkg::PCM_W-1:0]        hist1_q;
	logic signed [adpcm_pkg::PCM_W-1:0]        hist2_q;
	logic [adpcm_pkg::EXP_W-1:0]               exp_q;
	logic [adpcm_pkg::PAIR_W-1:0]              pair_q;
	logic [adpcm_pkg::FPOS_W-1:0]              fpos_q;
	logic [SAMPLE_COUNT_BITS-1:0]              done_q;
	logic [7:0]                                byte_q;
	logic                                      half_q;

	// output register
	logic                                      out_valid_q;
	logic signed [adpcm_pkg::PCM_W-1:0]        out_sample_q;
	logic                                      out_final_q;

	logic [adpcm_pkg::CFG_DATA_W-1:0]          bank;
	logic signed [adpcm_pkg::COEF_W-1:0]       c1;
	logic signed [adpcm_pkg::COEF_W-1:0]       c2;
	logic signed [adpcm_pkg::COEF_W-1:0]       mac_coef;
	logic signed [adpcm_pkg::PCM_W-1:0]        mac_hist;
	logic signed [adpcm_pkg::ACC_W-1:0]        acc;
	logic signed [adpcm_pkg::PCM_W-1:0]        sample;
	adpcm_pkg::mac_ctrl_t                      mac_ctrl;
	logic                                      in_take;
	logic                                      out_load;
	logic [SAMPLE_COUNT_BITS-1:0]              done_eff;
	logic [SAMPLE_COUNT_BITS-1:0]              done_next;
	logic [adpcm_pkg::FPOS_W-1:0]              fpos_eff;

	// ------------------------------------------------------------------
	// Coefficient pair select: bank by pair[2:1], half of it by pair[0]
	// ------------------------------------------------------------------
	assign bank = coef_q[pair_q[2:1]];
	assign c1   = pair_q[0] ? bank[31:16] : bank[63:48];
	assign c2   = pair_q[0] ? bank[15:0]  : bank[47:32];

	// ------------------------------------------------------------------
	// Shared multiply-accumulate unit and its step control
	// ------------------------------------------------------------------
	always_comb begin
		mac_ctrl.nibble   = half_q ? byte_q[3:0] : byte_q[7:4];
		mac_ctrl.exponent = exp_q;
		unique case (state_q)
			ST_LOAD:          mac_ctrl.op = adpcm_pkg::MAC_LOAD;
			ST_MAC1, ST_MAC2: mac_ctrl.op = adpcm_pkg::MAC_ACC;
			default:          mac_ctrl.op = adpcm_pkg::MAC_HOLD;
		endcase
		mac_coef = (state_q == ST_MAC2) ? c2 : c1;
		mac_hist = (state_q == ST_MAC2) ? hist2_q : hist1_q;
	end

	adpcm_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.coef (mac_coef),
		.hist (mac_hist),
		.acc  (acc)
	);

	assign sample = adpcm_pkg::sat_pcm(acc);

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign stream.ready     = (state_q == ST_IDLE);
	assign in_take          = stream.valid && stream.ready;
	// a finished sample waits in ST_DONE until the output register frees up
	assign out_load         = (state_q == ST_DONE) && (!out_valid_q || pcm.ready);

	assign pcm.valid        = out_valid_q;
	assign pcm.pcm_sample   = out_sample_q;
	assign pcm.final_sample = out_final_q;

	// stream start clears the counter and frame position before the byte is seen
	assign done_eff  = stream.stream_start ? '0 : done_q;
	assign fpos_eff  = stream.stream_start ? '0 : fpos_q;
	assign done_next = done_q + SAMPLE_COUNT_BITS'(1);

	// ------------------------------------------------------------------
	// Configuration writes; unknown indexes drop
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < adpcm_pkg::BANK_COUNT; i++)
				coef_q[i] <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				adpcm_pkg::REG_COEF_A, adpcm_pkg::REG_COEF_B,
				adpcm_pkg::REG_COEF_C, adpcm_pkg::REG_COEF_D: begin
					coef_q[cfg_index[1:0]] <= cfg_data;
				end
				adpcm_pkg::REG_SAMPLE_COUNT: begin
					count_q <= cfg_data[SAMPLE_COUNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer, decoder state and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hist1_q      <= '0;
			hist2_q      <= '0;
			exp_q        <= '0;
			pair_q       <= '0;
			fpos_q       <= '0;
			done_q       <= '0;
			byte_q       <= '0;
			half_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_final_q  <= 1'b0;
		end else begin
			// drop the output item once taken, unless a new one replaces it
			if (pcm.ready && !out_load)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (stream.stream_start) begin
							hist1_q <= '0;
							hist2_q <= '0;
							done_q  <= '0;
						end
						if (done_eff < count_q) begin
							if (fpos_eff == '0) begin
								exp_q  <= stream.data_byte[3:0];
								pair_q <= stream.data_byte[6:4];
								fpos_q <= adpcm_pkg::FPOS_W'(1);
							end else begin
								byte_q  <= stream.data_byte;
								half_q  <= 1'b0;
								state_q <= ST_LOAD;
							end
						end else if (stream.stream_start) begin
							fpos_q <= '0;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_MAC1;
				end
				ST_MAC1: begin
					state_q <= ST_MAC2;
				end
				ST_MAC2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= sample;
						out_final_q  <= (done_next == count_q);
						hist2_q      <= hist1_q;
						hist1_q      <= sample;
						done_q       <= done_next;
						// second nibble only if the count still allows it
						if (!half_q && (done_next != count_q)) begin
							half_q  <= 1'b1;
							state_q <= ST_LOAD;
						end else begin
							fpos_q  <= fpos_q + adpcm_pkg::FPOS_W'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// a sample is only produced while the count has room for it
	`ADPCM_ASSERT_NOW(a_sample_within_count, out_load, done_q < count_q)
	// the history shifts by one on every produced sample
	`ADPCM_ASSERT_NEXT(a_history_shift, out_load, hist2_q == $past(hist1_q))
	// a new byte is never taken while a byte is still being decoded
	`ADPCM_ASSERT_NOW(a_take_on_first_half, in_take && (state_q != ST_IDLE), 1'b0)

endmodule
